/* rtl/vdi_pkg.sv */
// Shared constants and types for the vertex dedup indexer.
// No dependencies; every other file but vdi_ram takes names from here by scope.
`timescale 1ns / 1ps

package vdi_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int NCOMP        = 8;
  localparam int COMP_W       = 32;
  localparam int ENTRY_W      = NCOMP * COMP_W;
  localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int VIDX_W       = 10;
  localparam int UCNT_W       = 11;

  localparam logic [COMP_W-1:0] MAG_MASK = 32'h7FFF_FFFF;
  localparam logic [COMP_W-1:0] INF_BITS = 32'h7F80_0000;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

endpackage

/* rtl/vdi_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; width and depth come in as parameters.
`timescale 1ns / 1ps

module vdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/vdi_match.sv */
// Entry comparator: IEEE equality on all eight single-precision components.
// Depends on vdi_pkg for component and entry widths.
`timescale 1ns / 1ps

module vdi_match (
  input  logic [vdi_pkg::ENTRY_W-1:0] entry,
  input  logic [vdi_pkg::ENTRY_W-1:0] vtx,
  output logic                        hit
);

  logic [vdi_pkg::NCOMP-1:0] comp_eq;

  always_comb begin
    logic [vdi_pkg::COMP_W-1:0] a;
    logic [vdi_pkg::COMP_W-1:0] b;
    logic [vdi_pkg::COMP_W-1:0] ma;
    logic [vdi_pkg::COMP_W-1:0] mb;
    for (int k = 0; k < vdi_pkg::NCOMP; k++) begin
      a  = entry[k*vdi_pkg::COMP_W +: vdi_pkg::COMP_W];
      b  = vtx[k*vdi_pkg::COMP_W +: vdi_pkg::COMP_W];
      ma = a & vdi_pkg::MAG_MASK;
      mb = b & vdi_pkg::MAG_MASK;
      if (ma > vdi_pkg::INF_BITS || mb > vdi_pkg::INF_BITS) begin
        comp_eq[k] = 1'b0;
      end else if (ma == '0 && mb == '0) begin
        comp_eq[k] = 1'b1;
      end else begin
        comp_eq[k] = (a == b);
      end
    end
  end

  assign hit = &comp_eq;

endmodule

/* rtl/vdi_ctrl.sv */
// Search sequencer: scans stored entries one per cycle, appends on a miss,
// and holds the result beat. Depends on vdi_pkg; drives the table RAM.
`timescale 1ns / 1ps

module vdi_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [vdi_pkg::ENTRY_W-1:0]  in_vtx,
  output logic [vdi_pkg::ENTRY_W-1:0]  vtx,
  input  logic                         hit,
  output vdi_pkg::ram_req_t            ram_req,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [vdi_pkg::VIDX_W-1:0]   vertex_index,
  output logic                         matched,
  output logic                         table_full,
  output logic [vdi_pkg::UCNT_W-1:0]   unique_count
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  localparam logic [vdi_pkg::CNT_W-1:0] CNT_MAX = vdi_pkg::CNT_W'(vdi_pkg::MAX_VERTICES);

  state_t                      state;
  state_t                      state_next;
  logic [vdi_pkg::CNT_W-1:0]   count;
  logic [vdi_pkg::CNT_W-1:0]   rd_idx;
  logic                        rd_pend;
  logic [vdi_pkg::IDX_W-1:0]   cmp_idx;
  logic                        found;
  logic [vdi_pkg::IDX_W-1:0]   found_idx;
  logic [vdi_pkg::CNT_W-1:0]   res_idx;
  logic                        res_full;
  logic                        issue;
  logic                        is_full;
  logic                        append;
  logic                        out_free;

  assign in_stall = (state != ST_IDLE);
  assign issue    = (state == ST_SCAN) && (rd_idx != count) && !found && !(rd_pend && hit);
  assign is_full  = (count == CNT_MAX);
  assign append   = (state == ST_DECIDE) && !found && !is_full;
  assign out_free = !out_valid || !out_stall;

  // Writes land only in DECIDE, after the scan has drained, so reads never overlap them.
  always_comb begin
    ram_req.re    = issue;
    ram_req.raddr = rd_idx[vdi_pkg::IDX_W-1:0];
    ram_req.we    = append;
    ram_req.waddr = count[vdi_pkg::IDX_W-1:0];
    ram_req.wdata = vtx;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SCAN;
      ST_SCAN:   if (!issue && !rd_pend) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rd_idx    <= '0;
      rd_pend   <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (state == ST_IDLE && in_valid) begin
        rd_idx <= '0;
        found  <= 1'b0;
      end
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (state == ST_SCAN && rd_pend && hit) begin
        found <= 1'b1;
      end
      if (append) begin
        count <= count + 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      vtx <= in_vtx;
    end
    if (issue) begin
      cmp_idx <= rd_idx[vdi_pkg::IDX_W-1:0];
    end
    if (state == ST_SCAN && rd_pend && hit) begin
      found_idx <= cmp_idx;
    end
    if (state == ST_DECIDE) begin
      res_full <= !found && is_full;
      if (found) begin
        res_idx <= vdi_pkg::CNT_W'(found_idx);
      end else if (is_full) begin
        res_idx <= '0;
      end else begin
        res_idx <= count;
      end
    end
    if (state == ST_DONE && out_free) begin
      vertex_index <= vdi_pkg::VIDX_W'(res_idx);
      matched      <= found;
      table_full   <= res_full;
      unique_count <= vdi_pkg::UCNT_W'(count);
    end
  end

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_idx <= count) else $error("scan index ran past the stored count");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX) else $error("stored count exceeds table depth");

  a_found_below: assert property (@(posedge clk) disable iff (rst)
    found |-> (vdi_pkg::CNT_W'(found_idx) < count))
    else $error("match index not below stored count");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (!ram_req.re && !rd_pend))
    else $error("table write overlaps a scan read");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DECIDE) |=> (count == $past(count)))
    else $error("stored count changed outside decide");

endmodule

/* rtl/vertex_dedup_indexer.sv */
// Top level of the vertex dedup indexer: table RAM, comparator, sequencer.
// Depends on vdi_pkg, vdi_ram, vdi_match and vdi_ctrl.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | pos_x..z, norm_x..z, tex_u, tex_v (32b)
//  output   | out_valid / out_stall| vertex_index, matched, table_full,
//           |                      | unique_count
//
// A miss scans all N stored entries, N the stored count, before the decide and done states;
// a match stops the scan at the hit entry. The table RAM gives one entry per cycle.
// in_stall stays high from accept until the result beat is loaded into the output
// register; the next vertex is accepted in the cycle after that at the earliest.
// A stalled output holds the sequencer in its final state.
// Reset clears the stored count and handshake state; the table needs no clear.
`timescale 1ns / 1ps

module vertex_dedup_indexer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [31:0]                pos_x,
  input  logic [31:0]                pos_y,
  input  logic [31:0]                pos_z,
  input  logic [31:0]                norm_x,
  input  logic [31:0]                norm_y,
  input  logic [31:0]                norm_z,
  input  logic [31:0]                tex_u,
  input  logic [31:0]                tex_v,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [vdi_pkg::VIDX_W-1:0] vertex_index,
  output logic                       matched,
  output logic                       table_full,
  output logic [vdi_pkg::UCNT_W-1:0] unique_count
);

  logic [vdi_pkg::ENTRY_W-1:0] in_vtx;
  logic [vdi_pkg::ENTRY_W-1:0] vtx;
  logic [vdi_pkg::ENTRY_W-1:0] rd_data;
  logic                        hit;
  vdi_pkg::ram_req_t           ram_req;

  assign in_vtx = {tex_v, tex_u, norm_z, norm_y, norm_x, pos_z, pos_y, pos_x};

  vdi_ram #(
    .WIDTH (vdi_pkg::ENTRY_W),
    .DEPTH (vdi_pkg::MAX_VERTICES)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  vdi_match u_match (
    .entry (rd_data),
    .vtx   (vtx),
    .hit   (hit)
  );

  vdi_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_vtx       (in_vtx),
    .vtx          (vtx),
    .hit          (hit),
    .ram_req      (ram_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex_index (vertex_index),
    .matched      (matched),
    .table_full   (table_full),
    .unique_count (unique_count)
  );

endmodule

/* tb/vertex_dedup_indexer_test.sv */
// Testbench for vertex_dedup_indexer: vertex feed, stall-driven receiver and a welding predictor.
// Depends on vdi_pkg and the vertex_dedup_indexer RTL; needs no other file.
`timescale 1ns / 1ps

module vertex_dedup_indexer_test;

  localparam int RANDOM_ITEMS = 557;
  localparam int QUIET_LIMIT  = 20000;
  localparam int SETTLE       = 2100;
  localparam int MAXV         = vdi_pkg::MAX_VERTICES;

  localparam logic [31:0] POS_ZERO = 32'h0000_0000;
  localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] POS_INF  = 32'h7F80_0000;
  localparam logic [31:0] NEG_INF  = 32'hFF80_0000;
  localparam logic [31:0] QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] SNAN     = 32'h7F80_0001;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_NAN  = 32'h7FFF_FFFF;
  localparam logic [31:0] MAX_FIN  = 32'h7F7F_FFFF;
  localparam logic [31:0] DENORM   = 32'h0000_0001;
  localparam logic [31:0] NDENORM  = 32'h8000_0001;
  localparam logic [31:0] ONE      = 32'h3F80_0000;
  localparam logic [31:0] MINUS_1  = 32'hBF80_0000;

  // component 0 is pos_x, component 7 is tex_v
  typedef logic [7:0][31:0] vertex_t;

  typedef struct packed {
    logic [vdi_pkg::VIDX_W-1:0] index;
    logic                       hit;
    logic                       full;
    logic [vdi_pkg::UCNT_W-1:0] count;
  } weld_result_t;

  logic    clk;
  logic    rst      = 1'b1;
  logic    in_valid = 1'b0;
  logic    out_stall = 1'b0;
  vertex_t on_bus   = '0;

  logic                       in_stall;
  logic                       out_valid;
  logic [vdi_pkg::VIDX_W-1:0] vertex_index;
  logic                       matched;
  logic                       table_full;
  logic [vdi_pkg::UCNT_W-1:0] unique_count;

  vertex_t      vertex_feed[$];
  vertex_t      sent_pool[$];
  weld_result_t weld_answers[$];

  vertex_t mesh_table [MAXV];
  int      mesh_count = 0;

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  int   errors = 0;
  int   results_checked = 0;
  int   vertices_sent = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_off_left = 0;
  logic hold_off_done = 1'b0;
  int   quiet_cycles = 0;

  vertex_dedup_indexer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pos_x        (on_bus[0]),
    .pos_y        (on_bus[1]),
    .pos_z        (on_bus[2]),
    .norm_x       (on_bus[3]),
    .norm_y       (on_bus[4]),
    .norm_z       (on_bus[5]),
    .tex_u        (on_bus[6]),
    .tex_v        (on_bus[7]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex_index (vertex_index),
    .matched      (matched),
    .table_full   (table_full),
    .unique_count (unique_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit same_value(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    ma = a & 32'h7FFF_FFFF;
    mb = b & 32'h7FFF_FFFF;
    if (ma > POS_INF || mb > POS_INF) return 1'b0;
    if (ma == 32'd0 && mb == 32'd0) return 1'b1;
    return a == b;
  endfunction

  function automatic bit same_vertex(vertex_t a, vertex_t b);
    for (int k = 0; k < 8; k++)
      if (!same_value(a[k], b[k])) return 1'b0;
    return 1'b1;
  endfunction

  // Search stored entries, append on a miss, flag a full table.
  function automatic weld_result_t weld_vertex(vertex_t v);
    weld_result_t r;
    int           slot;
    bit           hit;
    slot = 0;
    hit  = 1'b0;
    r.full = 1'b0;
    for (int i = 0; i < mesh_count; i++)
      if (same_vertex(mesh_table[i], v)) begin
        slot = i;
        hit  = 1'b1;
      end
    if (!hit) begin
      if (mesh_count >= MAXV) begin
        r.full = 1'b1;
        slot   = 0;
      end else begin
        slot = mesh_count;
        mesh_table[slot] = v;
        mesh_count++;
      end
    end
    r.index = slot[vdi_pkg::VIDX_W-1:0];
    r.hit   = hit;
    r.count = mesh_count[vdi_pkg::UCNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // Sample both channels: check result beats, predict accepted vertex beats.
  always @(posedge clk) begin : watch
    weld_result_t want;
    in_taken  <= in_valid && !in_stall;
    out_taken <= out_valid && !out_stall;
    if (!rst && out_valid && !out_stall) begin
      if (weld_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, vertex_index %0d", $time, vertex_index);
      end else begin
        want = weld_answers.pop_front();
        check_field("vertex_index", want.index, vertex_index);
        check_field("matched", want.hit, matched);
        check_field("table_full", want.full, table_full);
        check_field("unique_count", want.count, unique_count);
        results_checked++;
      end
    end
    if (!rst && in_valid && !in_stall)
      weld_answers = {weld_answers, weld_vertex(on_bus)};
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the beat until taken, then wait a drawn gap before the next one.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_valid) begin
        vertices_sent++;
        gap_left = ((vertices_sent / 50) % 4 == 2) ? 0 : $urandom_range(0, 18);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (vertex_feed.size() > 0) begin
        on_bus   <= vertex_feed.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
    end else if (!hold_off_done && results_checked >= 150) begin
      hold_off_left <= 600;
      hold_off_done <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_taken)
        stall_left = ((results_checked / 40) % 4 == 1) ? 0 : $urandom_range(0, 18);
      if (stall_left > 0 && out_valid) stall_left--;
      out_stall <= (hold_off_left > 0) || (stall_left > 0);
    end
  end

  function automatic logic [31:0] special_comp();
    case ($urandom_range(0, 12))
      0:       return POS_ZERO;
      1:       return NEG_ZERO;
      2:       return POS_INF;
      3:       return NEG_INF;
      4:       return QNAN;
      5:       return SNAN;
      6:       return MAX_FIN;
      7:       return DENORM;
      8:       return NDENORM;
      9:       return ONE;
      10:      return MINUS_1;
      11:      return ALL_ONES;
      default: return MAX_NAN;
    endcase
  endfunction

  function automatic vertex_t fresh_vertex(bit wild);
    vertex_t v;
    for (int k = 0; k < 8; k++)
      if (wild || $urandom_range(0, 3) == 0) v[k] = $urandom;
      else if ($urandom_range(0, 2) == 0) v[k] = special_comp();
      else v[k] = {1'b0, 8'h7E + 8'($urandom_range(0, 3)), 23'($urandom_range(0, 3))};
    return v;
  endfunction

  // Replay a sent vertex, swapping the sign of some zero components.
  function automatic vertex_t echo_vertex();
    vertex_t v;
    v = sent_pool[$urandom_range(0, sent_pool.size() - 1)];
    for (int k = 0; k < 8; k++)
      if (v[k][30:0] == 31'd0 && $urandom_range(0, 1) == 1) v[k][31] = ~v[k][31];
    return v;
  endfunction

  task automatic offer(vertex_t v);
    vertex_feed = {vertex_feed, v};
    sent_pool   = {sent_pool, v};
  endtask

  task automatic wait_drained();
    while (vertex_feed.size() != 0 || in_valid || weld_answers.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    vertex_t v;
    int      pick;
    int      k;
    int      b;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    offer({8{POS_ZERO}});
    offer({8{NEG_ZERO}});
    v = {8{POS_ZERO}};
    v[3] = NEG_ZERO;
    v[6] = NEG_ZERO;
    offer(v);
    offer({8{ALL_ONES}});
    offer({8{ALL_ONES}});
    offer({8{QNAN}});
    v = {8{ONE}};
    v[2] = SNAN;
    offer(v);
    offer(v);
    offer({8{POS_INF}});
    offer({8{NEG_INF}});
    offer({8{POS_INF}});
    offer({8{MAX_FIN}});
    offer({8{DENORM}});
    offer({8{NDENORM}});
    offer({8{DENORM}});
    offer({8{ONE}});
    v = {8{ONE}};
    v[7] = MINUS_1;
    offer(v);
    offer({8{32'hAAAA_AAAA}});
    offer({8{32'h5555_5555}});
    v = {8{ONE}};
    v[0] = 32'h3F80_0001;
    offer(v);
    offer({8{POS_ZERO}});
    offer({8{ONE}});
    offer({8{MAX_NAN}});

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        v = echo_vertex();
      end else if (pick < 11) begin
        v = echo_vertex();
        k = $urandom_range(0, 7);
        b = $urandom_range(0, 31);
        v[k][b] = ~v[k][b];
      end else begin
        v = fresh_vertex(pick >= 17);
      end
      offer(v);
    end
    wait_drained();

    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* vertex_dedup_indexer.f */
rtl/vdi_pkg.sv
rtl/vdi_ram.sv
rtl/vdi_match.sv
rtl/vdi_ctrl.sv
rtl/vertex_dedup_indexer.sv
tb/vertex_dedup_indexer_test.sv
